// ----- rtl/core/tps_pkg.sv -----
// Shared types, constants and codes for the thermal profile sequencer.
// Used by all modules under rtl/core.
package tps_pkg;

  localparam int STEPS = 16;
  localparam int IDX_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CNT_W = $clog2(STEPS + 1);

  localparam logic [2:0] FN_STEP    = 3'd0;
  localparam logic [2:0] FN_APPEND  = 3'd1;
  localparam logic [2:0] FN_CLEAR   = 3'd2;
  localparam logic [2:0] FN_RESTART = 3'd3;
  localparam logic [2:0] FN_REPEATS = 3'd4;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [1:0] CFG_MARGIN    = 2'd0;
  localparam logic [1:0] CFG_POST_TEMP = 2'd1;
  localparam logic [1:0] CFG_POST_EN   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [7:0]         repeat_value;
    logic [15:0]        entry_hold;
    logic signed [15:0] entry_temp;
    logic [15:0]        tick_delta;
    logic signed [15:0] meas_temp;
    logic [2:0]         func;
  } item_t;

  typedef struct packed {
    logic               post_cycle_enable;
    logic signed [15:0] post_cycle_temp;
    logic [7:0]         temp_margin;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         op_status;
    logic               curve_loaded;
    logic [7:0]         repeats_left;
    logic [15:0]        stable_elapsed;
    logic               finished;
    logic signed [15:0] set_temp;
    logic               temp_valid;
  } result_t;

  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [31:0]      wr_data;
    logic [IDX_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ----- rtl/core/tps_step_mem.sv -----
// Step table: one write port, one read port, registered read data.
// Depends on tps_pkg for depth and the request struct.
module tps_step_mem (
  input  logic                clk,
  input  tps_pkg::mem_req_t   req,
  output logic [31:0]         rd_data
);

  logic [31:0] mem [tps_pkg::STEPS];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem[req.rd_addr];
  end

endmodule

// ----- rtl/core/tps_seq.sv -----
// Sequencer control: item decode, table read-modify-write, state registers.
// Depends on tps_pkg; drives the step table in tps_step_mem.
module tps_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  tps_pkg::item_t      item_in,
  input  tps_pkg::cfg_t       cfg,
  output tps_pkg::mem_req_t   mem_req,
  input  logic [31:0]         mem_rd_data,
  output logic                res_valid,
  input  logic                res_ready,
  output tps_pkg::result_t    res
);

  tps_pkg::state_t state, state_next;
  tps_pkg::item_t  item;

  logic [tps_pkg::CNT_W-1:0] entry_count, entry_count_next;
  logic [tps_pkg::IDX_W-1:0] current_step, current_step_next;
  logic [tps_pkg::IDX_W-1:0] restart_step, restart_step_next;
  logic [15:0]               stable_time, stable_time_next;
  logic [7:0]                repeat_counter, repeat_counter_next;
  logic                      done_flag, done_flag_next;
  logic [1:0]                status, status_next;
  logic                      fwd_hit;
  logic [15:0]               fwd_temp;

  logic signed [15:0] target;
  logic [15:0]        hold;
  logic signed [17:0] band_lo, band_hi, cur_x;
  logic               in_band;
  logic [16:0]        sum;
  logic [15:0]        stable_acc;
  logic               use_post;
  logic               accept;

  assign accept     = item_valid && item_ready;
  assign item_ready = (state == tps_pkg::ST_IDLE);
  assign target     = $signed(mem_rd_data[15:0]);
  assign hold       = mem_rd_data[31:16];
  assign band_lo    = {{2{target[15]}}, target} - $signed({10'b0, cfg.temp_margin});
  assign band_hi    = {{2{target[15]}}, target} + $signed({10'b0, cfg.temp_margin});
  assign cur_x      = {{2{item.meas_temp[15]}}, item.meas_temp};
  assign in_band    = (cur_x > band_lo) && (cur_x < band_hi);
  assign sum        = {1'b0, stable_time} + {1'b0, item.tick_delta};
  assign stable_acc = in_band ? (sum[16] ? 16'hFFFF : sum[15:0]) : stable_time;
  assign use_post   = done_flag && cfg.post_cycle_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tps_pkg::ST_IDLE;
      entry_count    <= '0;
      current_step   <= '0;
      restart_step   <= '0;
      stable_time    <= '0;
      repeat_counter <= '0;
      done_flag      <= 1'b0;
    end else begin
      state          <= state_next;
      entry_count    <= entry_count_next;
      current_step   <= current_step_next;
      restart_step   <= restart_step_next;
      stable_time    <= stable_time_next;
      repeat_counter <= repeat_counter_next;
      done_flag      <= done_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_in;
    end
    if (state == tps_pkg::ST_EXEC) begin
      status   <= status_next;
      fwd_hit  <= mem_req.wr_en && (mem_req.wr_addr == mem_req.rd_addr);
      fwd_temp <= mem_req.wr_data[15:0];
    end
  end

  always_comb begin
    state_next          = state;
    entry_count_next    = entry_count;
    current_step_next   = current_step;
    restart_step_next   = restart_step;
    stable_time_next    = stable_time;
    repeat_counter_next = repeat_counter;
    done_flag_next      = done_flag;
    status_next         = tps_pkg::STAT_OK;
    mem_req.wr_en       = 1'b0;
    mem_req.wr_addr     = entry_count[tps_pkg::IDX_W-1:0];
    mem_req.wr_data     = {item.entry_hold, item.entry_temp};
    res_valid           = 1'b0;

    unique case (state)
      tps_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = tps_pkg::ST_EXEC;
        end
      end
      tps_pkg::ST_EXEC: begin
        state_next = tps_pkg::ST_RESULT;
        unique case (item.func)
          tps_pkg::FN_STEP: begin
            if (entry_count == '0) begin
              status_next = tps_pkg::STAT_EMPTY;
            end else if (!use_post) begin
              if (stable_acc >= hold) begin
                stable_time_next = '0;
                if (tps_pkg::CNT_W'(current_step) + tps_pkg::CNT_W'(1) < entry_count) begin
                  current_step_next = current_step + tps_pkg::IDX_W'(1);
                end else if (repeat_counter != '0) begin
                  current_step_next   = restart_step;
                  repeat_counter_next = repeat_counter - 8'd1;
                end else begin
                  done_flag_next = 1'b1;
                end
              end else begin
                stable_time_next = stable_acc;
              end
            end
          end
          tps_pkg::FN_APPEND: begin
            if (entry_count >= tps_pkg::CNT_W'(tps_pkg::STEPS)) begin
              status_next = tps_pkg::STAT_FULL;
            end else begin
              mem_req.wr_en    = 1'b1;
              entry_count_next = entry_count + tps_pkg::CNT_W'(1);
              if (entry_count == '0) begin
                current_step_next = '0;
                restart_step_next = '0;
              end
            end
          end
          tps_pkg::FN_CLEAR: begin
            entry_count_next    = '0;
            current_step_next   = '0;
            restart_step_next   = '0;
            repeat_counter_next = '0;
            done_flag_next      = 1'b0;
          end
          tps_pkg::FN_RESTART: begin
            if (entry_count == '0) begin
              status_next = tps_pkg::STAT_EMPTY;
            end else begin
              restart_step_next = tps_pkg::IDX_W'(entry_count - tps_pkg::CNT_W'(1));
            end
          end
          tps_pkg::FN_REPEATS: begin
            repeat_counter_next = item.repeat_value;
            done_flag_next      = 1'b0;
          end
          default: begin
          end
        endcase
      end
      tps_pkg::ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = tps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tps_pkg::ST_IDLE;
      end
    endcase

    mem_req.rd_addr = (state == tps_pkg::ST_EXEC) ? current_step_next : current_step;
  end

  always_comb begin
    res.temp_valid     = (entry_count != '0);
    res.curve_loaded   = (entry_count != '0);
    res.finished       = done_flag;
    res.stable_elapsed = stable_time;
    res.repeats_left   = repeat_counter;
    res.op_status      = status;
    if (entry_count == '0) begin
      res.set_temp = '0;
    end else if (use_post) begin
      res.set_temp = cfg.post_cycle_temp;
    end else if (fwd_hit) begin
      res.set_temp = $signed(fwd_temp);
    end else begin
      res.set_temp = $signed(mem_rd_data[15:0]);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= tps_pkg::CNT_W'(tps_pkg::STEPS))
    else $error("entry count beyond table depth");

  a_step_in_table: assert property (@(posedge clk) disable iff (rst)
    entry_count != '0 |-> tps_pkg::CNT_W'(current_step) < entry_count &&
                          tps_pkg::CNT_W'(restart_step) < entry_count)
    else $error("step pointer outside stored curve");

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == tps_pkg::ST_EXEC)
    else $error("accepted beat did not start execution");

  a_done_by_step: assert property (@(posedge clk) disable iff (rst)
    $rose(done_flag) |-> $past(state == tps_pkg::ST_EXEC && item.func == tps_pkg::FN_STEP))
    else $error("finished set outside a step item");

endmodule

// ----- rtl/core/thermal_profile_sequencer_core.sv -----
// Top level of the thermal profile sequencer: config registers, output register,
// sequencer and step table. Depends on tps_pkg, tps_seq and tps_step_mem.
//
// Usage: a command beat on the s_ channel (tuser = func, tdata = operands)
// gives exactly one status beat on the m_ channel. Func 0 steps the profile
// with a measured temperature and elapsed ticks, 1 appends a step, 2 clears
// the curve, 3 marks the last step as loop restart, 4 loads the repeat count.
// The cfg channel writes temp_margin (0), post_cycle_temp (1) and
// post_cycle_enable (2); it is always ready and must only be used while idle.
// Each command runs from acceptance to result as a table read of the current
// step, then evaluation and update in ST_EXEC (re-reading the new step), then
// the result formed in ST_RESULT. A new command is taken only once the previous
// one has left ST_RESULT, which needs the output register free or draining, so
// commands do not overlap. A result waits in the output register while m_tready is low;
// a further result then holds the sequencer, and s_tready stays low.
// Reset clears the curve, pointers, counters and config to their defaults.
// The step table is not cleared; entries are only read once appended.
module thermal_profile_sequencer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // meas_temp, tick_delta, entry_temp, entry_hold, repeat_value
  input  logic [2:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // set_temp, finished, stable_elapsed, repeats_left,
                                 // curve_loaded, op_status, zero pad
  output logic [0:0]  m_tuser,   // temp_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  tps_pkg::cfg_t     cfg;
  tps_pkg::item_t    item_in;
  tps_pkg::mem_req_t mem_req;
  tps_pkg::result_t  res, out;
  logic [31:0]       mem_rd_data;
  logic              res_valid, res_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_margin       <= 8'd8;
      cfg.post_cycle_temp   <= '0;
      cfg.post_cycle_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tps_pkg::CFG_MARGIN:    cfg.temp_margin       <= cfg_data[7:0];
        tps_pkg::CFG_POST_TEMP: cfg.post_cycle_temp   <= $signed(cfg_data);
        tps_pkg::CFG_POST_EN:   cfg.post_cycle_enable <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign item_in.func         = s_tuser;
  assign item_in.meas_temp    = $signed(s_tdata[15:0]);
  assign item_in.tick_delta   = s_tdata[31:16];
  assign item_in.entry_temp   = $signed(s_tdata[47:32]);
  assign item_in.entry_hold   = s_tdata[63:48];
  assign item_in.repeat_value = s_tdata[71:64];

  tps_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (s_tvalid),
    .item_ready  (s_tready),
    .item_in     (item_in),
    .cfg         (cfg),
    .mem_req     (mem_req),
    .mem_rd_data (mem_rd_data),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  tps_step_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (mem_rd_data)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out <= res;
    end
  end

  assign m_tuser = out.temp_valid;
  assign m_tdata = {4'b0, out.op_status, out.curve_loaded, out.repeats_left,
                    out.stable_elapsed, out.finished, out.set_temp};

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for thermal_profile_sequencer_core: a directed table, then random
// well-formed profiles mixed with noise, checked against a cycle-free predictor.
// Depends on tps_pkg and the core RTL only.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tps_pkg::*;

  localparam logic [2:0] FN_NOP_FIRST = 3'd5;
  localparam logic [2:0] FN_NOP_LAST  = 3'd7;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_LIMIT  = 4000;

  typedef struct {
    bit         is_cfg;
    logic [1:0] reg_idx;
    logic [15:0] reg_val;
    item_t      it;
    int         count;
    bit         typed;
    result_t    want;
  } row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  thermal_profile_sequencer_core DUT (.*);

  // predictor state
  logic [31:0]        steps_mem [STEPS];
  int                 n_steps = 0;
  int                 cur_idx = 0;
  int                 loop_idx = 0;
  logic [15:0]        stable_acc = '0;
  logic [7:0]         reps_acc = '0;
  logic               done_acc = 1'b0;
  logic [7:0]         margin_r = 8'd8;
  logic signed [15:0] post_temp_r = '0;
  logic               post_en_r = 1'b0;

  result_t pending_status [$];
  int      errors = 0;
  int      n_sent = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  int      hold_off = 0;
  int      quiet_cycles = 0;
  result_t got_r, exp_r;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic result_t predict_status(item_t it);
    result_t    r;
    int         tgt, hold, cur, sum;
    logic [1:0] st;
    st = STAT_OK;
    case (it.func)
      FN_STEP: begin
        if (n_steps == 0) begin
          st = STAT_EMPTY;
        end else if (!(done_acc && post_en_r)) begin
          tgt  = int'($signed(steps_mem[cur_idx[IDX_W-1:0]][15:0]));
          hold = int'(steps_mem[cur_idx[IDX_W-1:0]][31:16]);
          cur  = int'(it.meas_temp);
          if (cur > tgt - int'(margin_r) && cur < tgt + int'(margin_r)) begin
            sum = int'(stable_acc) + int'(it.tick_delta);
            stable_acc = (sum > 65535) ? 16'hFFFF : sum[15:0];
          end
          if (int'(stable_acc) >= hold) begin
            stable_acc = '0;
            if (cur_idx + 1 < n_steps) begin
              cur_idx++;
            end else if (reps_acc != 8'd0) begin
              cur_idx = loop_idx;
              reps_acc--;
            end else begin
              done_acc = 1'b1;
            end
          end
        end
      end
      FN_APPEND: begin
        if (n_steps >= STEPS) begin
          st = STAT_FULL;
        end else begin
          steps_mem[n_steps[IDX_W-1:0]] = {it.entry_hold, it.entry_temp};
          if (n_steps == 0) begin
            cur_idx = 0;
            loop_idx = 0;
          end
          n_steps++;
        end
      end
      FN_CLEAR: begin
        n_steps = 0;
        cur_idx = 0;
        loop_idx = 0;
        reps_acc = '0;
        done_acc = 1'b0;
      end
      FN_RESTART: begin
        if (n_steps == 0) st = STAT_EMPTY;
        else loop_idx = n_steps - 1;
      end
      FN_REPEATS: begin
        reps_acc = it.repeat_value;
        done_acc = 1'b0;
      end
      default: ;
    endcase
    r.temp_valid     = (n_steps != 0);
    r.curve_loaded   = (n_steps != 0);
    r.finished       = done_acc;
    r.stable_elapsed = stable_acc;
    r.repeats_left   = reps_acc;
    r.op_status      = st;
    if (n_steps == 0) r.set_temp = '0;
    else if (done_acc && post_en_r) r.set_temp = post_temp_r;
    else r.set_temp = steps_mem[cur_idx[IDX_W-1:0]][15:0];
    return r;
  endfunction

  function automatic row_t drow(logic [2:0] f, int a, int b, int c, int d, int e, int n = 1);
    row_t r;
    r.is_cfg  = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.it.func = f;
    r.it.meas_temp    = a[15:0];
    r.it.tick_delta   = b[15:0];
    r.it.entry_temp   = c[15:0];
    r.it.entry_hold   = d[15:0];
    r.it.repeat_value = e[7:0];
    r.count = n;
    r.typed = 1'b0;
    r.want  = '0;
    return r;
  endfunction

  function automatic row_t tdrow(logic [2:0] f, int a, int b, int c, int d, int e, result_t w);
    row_t r;
    r = drow(f, a, b, c, d, e);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic row_t crow(logic [1:0] idx, logic [15:0] val);
    row_t r;
    r = drow(FN_NOP_FIRST, 0, 0, 0, 0, 0, 0);
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  task automatic push_item(item_t it, bit typed = 1'b0, result_t want = '0);
    result_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.func;
    s_tdata  <= {it.repeat_value, it.entry_hold, it.entry_temp, it.tick_delta,
                 it.meas_temp};
    do @(posedge clk); while (!s_tready);
    r = predict_status(it);
    pending_status.push_back(typed ? want : r);
    if (it.func <= FN_REPEATS) n_sent++;
  endtask

  task automatic drain_status();
    s_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_MARGIN:    margin_r = val[7:0];
      CFG_POST_TEMP: post_temp_r = val;
      CFG_POST_EN:   post_en_r = val[0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(logic [7:0] m, logic [15:0] pt, logic en);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(CFG_MARGIN, {junk[7:0], m});
    write_reg(CFG_POST_TEMP, pt);
    write_reg(CFG_POST_EN, {junk[22:8], en});
  endtask

  function automatic item_t noise_item();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[74:0];
  endfunction

  // maybe clear, load a curve (usually short), set the loop mark and maybe repeats, then step mostly near the targets
  task automatic run_profile();
    item_t it;
    int    n, mark, budget, tgt, t, m, v;
    if ($urandom_range(3) != 0) begin
      it = noise_item();
      it.func = FN_CLEAR;
      push_item(it);
    end
    n = ($urandom_range(9) == 0) ? int'($urandom_range(15, 18)) : int'($urandom_range(1, 4));
    mark = $urandom_range(0, n);
    for (int k = 0; k < n; k++) begin
      it = noise_item();
      it.func = FN_APPEND;
      v = $urandom_range(0, 300);
      if ($urandom_range(9) == 0) v = $urandom_range(0, 65535);
      it.entry_hold = v[15:0];
      push_item(it);
      if (k == mark) begin
        it.func = FN_RESTART;
        push_item(it);
      end
    end
    if ($urandom_range(4) != 0) begin
      it = noise_item();
      it.func = FN_REPEATS;
      v = ($urandom_range(19) == 0) ? int'($urandom_range(0, 255)) : int'($urandom_range(0, 3));
      it.repeat_value = v[7:0];
      push_item(it);
    end
    budget = $urandom_range(10, 60);
    for (int k = 0; k < budget; k++) begin
      it = noise_item();
      it.func = FN_STEP;
      if (n_steps != 0 && $urandom_range(6) != 0) begin
        tgt = int'($signed(steps_mem[cur_idx[IDX_W-1:0]][15:0]));
        m = int'(margin_r) + 2;
        t = tgt + int'($urandom_range(0, 2 * m)) - m;
        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        it.meas_temp = t[15:0];
      end
      if ($urandom_range(7) != 0) begin
        v = $urandom_range(0, 200);
        it.tick_delta = v[15:0];
      end
      push_item(it);
      if (done_acc && $urandom_range(3) == 0) break;
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        hold_off--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_r.temp_valid     = m_tuser[0];
      got_r.set_temp       = m_tdata[15:0];
      got_r.finished       = m_tdata[16];
      got_r.stable_elapsed = m_tdata[32:17];
      got_r.repeats_left   = m_tdata[40:33];
      got_r.curve_loaded   = m_tdata[41];
      got_r.op_status      = m_tdata[43:42];
      if (pending_status.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t: status beat with nothing pending", $realtime);
      end else begin
        exp_r = pending_status.pop_front();
        if (got_r.temp_valid !== exp_r.temp_valid || got_r.set_temp !== exp_r.set_temp ||
            got_r.finished !== exp_r.finished ||
            got_r.stable_elapsed !== exp_r.stable_elapsed ||
            got_r.repeats_left !== exp_r.repeats_left ||
            got_r.curve_loaded !== exp_r.curve_loaded ||
            got_r.op_status !== exp_r.op_status) begin
          errors++;
          if (errors <= 10)
            $display({"%0t: status mismatch exp v=%0d t=%0d f=%0d s=%0d r=%0d l=%0d st=%0d",
                      "\n    got v=%0d t=%0d f=%0d s=%0d r=%0d l=%0d st=%0d"},
                     $realtime, exp_r.temp_valid, exp_r.set_temp, exp_r.finished,
                     exp_r.stable_elapsed, exp_r.repeats_left, exp_r.curve_loaded,
                     exp_r.op_status,
                     got_r.temp_valid, got_r.set_temp, got_r.finished,
                     got_r.stable_elapsed, got_r.repeats_left, got_r.curve_loaded,
                     got_r.op_status);
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready) || rst)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    row_t  plan [$];
    int    target;
    bit    paused;
    logic [31:0] rv;
    // typed results: {op_status, curve_loaded, repeats_left, stable_elapsed, finished,
    //                 set_temp, temp_valid}
    plan.push_back(tdrow(FN_STEP, 0, 0, 0, 0, 0,
                         {STAT_EMPTY, 1'b0, 8'd0, 16'd0, 1'b0, 16'd0, 1'b0}));
    plan.push_back(tdrow(FN_RESTART, 0, 0, 0, 0, 0,
                         {STAT_EMPTY, 1'b0, 8'd0, 16'd0, 1'b0, 16'd0, 1'b0}));
    plan.push_back(tdrow(FN_REPEATS, 0, 0, 0, 0, 255,
                         {STAT_OK, 1'b0, 8'd255, 16'd0, 1'b0, 16'd0, 1'b0}));
    plan.push_back(tdrow(FN_NOP_LAST, -1, 65535, -1, 65535, 255,
                         {STAT_OK, 1'b0, 8'd255, 16'd0, 1'b0, 16'd0, 1'b0}));
    plan.push_back(drow(FN_APPEND, 0, 0, -32768, 0, 0));
    plan.push_back(drow(FN_APPEND, 0, 0, 32767, 65535, 0));
    plan.push_back(drow(FN_RESTART, 0, 0, 0, 0, 0));
    plan.push_back(drow(FN_STEP, -32768, 5, 0, 0, 0));
    plan.push_back(drow(FN_STEP, 32767, 65535, 0, 0, 0));   // reaches the hold, loops back
    plan.push_back(drow(FN_STEP, 32759, 9, 0, 0, 0));       // on the band edge
    plan.push_back(drow(FN_REPEATS, 0, 0, 0, 0, 0));
    plan.push_back(drow(FN_STEP, 32760, 65535, 0, 0, 0));   // finishes
    plan.push_back(drow(FN_STEP, 0, 1, 0, 0, 0));
    plan.push_back(drow(FN_STEP, 32767, 7, 0, 0, 0));       // finished, last step re-run
    plan.push_back(drow(FN_CLEAR, 0, 0, 0, 0, 0));          // stable time survives
    plan.push_back(drow(FN_NOP_FIRST, 0, 0, 0, 0, 0));
    plan.push_back(crow(CFG_POST_EN, 16'd1));
    plan.push_back(crow(CFG_POST_TEMP, 16'h8000));
    plan.push_back(drow(FN_APPEND, 0, 0, 50, 1, 0));
    plan.push_back(drow(FN_STEP, 50, 1, 0, 0, 0));
    plan.push_back(drow(FN_STEP, 50, 1, 0, 0, 0));          // post-cycle, state frozen
    plan.push_back(drow(FN_REPEATS, 0, 0, 0, 0, 3));
    plan.push_back(drow(FN_APPEND, 0, 0, 1000, 3, 0, 15));
    plan.push_back(drow(FN_APPEND, 0, 0, 2000, 3, 0));      // table full
    plan.push_back(crow(CFG_MARGIN, 16'd0));
    plan.push_back(drow(FN_STEP, 50, 100, 0, 0, 0));
    plan.push_back(crow(CFG_MARGIN, 16'hFF));

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain_status();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        repeat (plan[i].count) push_item(plan[i].it, plan[i].typed, plan[i].want);
      end
    end

    n_sent = 0;
    paused = 1'b0;
    for (int p = 0; p < 4; p++) begin
      drain_status();
      rv = $urandom;
      case (p)
        0: begin
          send_idle_pct = 0;  stall_pct = 0;
          load_settings(8'd8, rv[15:0], 1'b0);
          hold_off = 300;
        end
        1: begin
          send_idle_pct = 52; stall_pct = 0;
          load_settings(8'd255, 16'h7FFF, 1'b1);
        end
        2: begin
          send_idle_pct = 0;  stall_pct = 52;
          load_settings(8'd0, 16'h8000, 1'b1);
          hold_off = 300;
        end
        default: begin
          send_idle_pct = 33; stall_pct = 33;
          load_settings(rv[23:16] & 8'h3F, rv[15:0], 1'b0);
        end
      endcase
      target = (p + 1) * RANDOM_ITEMS / 4;
      while (n_sent < target) begin
        if ($urandom_range(99) < 15) push_item(noise_item());
        else run_profile();
        if (p == 1 && !paused && n_sent >= RANDOM_ITEMS * 3 / 8) begin
          drain_status();
          paused = 1'b1;
        end
      end
    end

    drain_status();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
